### src/cba_pkg.sv
package cba_pkg;

   // Built size of the disk and of the file directory.
   localparam int MAX_DISK_BLOCKS   = 256;
   localparam int DIRECTORY_ENTRIES = 16;

   // Fixed field widths of the ports.
   localparam int ID_W     = 16;
   localparam int REQ_W    = 9;
   localparam int START_W  = 8;
   localparam int COUNT_W  = 9;
   localparam int CFG_W    = 9;
   localparam int STATUS_W = 3;

   // Internal widths that follow from the built sizes.
   localparam int BLK_W = $clog2(MAX_DISK_BLOCKS);
   localparam int CNT_W = BLK_W + 1;
   localparam int SUM_W = ((CNT_W > REQ_W) ? CNT_W : REQ_W) + 1;
   localparam int DIR_W = (DIRECTORY_ENTRIES > 1) ? $clog2(DIRECTORY_ENTRIES) : 1;

   localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(256);

   localparam logic OP_CREATE = 1'b0;
   localparam logic OP_DELETE = 1'b1;

   localparam logic [STATUS_W-1:0] ST_OK       = STATUS_W'(0);
   localparam logic [STATUS_W-1:0] ST_DUP      = STATUS_W'(1);
   localparam logic [STATUS_W-1:0] ST_FEW      = STATUS_W'(2);
   localparam logic [STATUS_W-1:0] ST_NORUN    = STATUS_W'(3);
   localparam logic [STATUS_W-1:0] ST_FULL     = STATUS_W'(4);
   localparam logic [STATUS_W-1:0] ST_NOTFOUND = STATUS_W'(5);

   typedef struct packed {
      logic load;
      logic dir_step;
      logic map_step;
      logic finish;
      logic clear_step;
      logic mark_step;
   } cmd_type;

   typedef struct packed {
      logic dir_last;
      logic map_last;
      logic skip_map;
      logic res_ok;
      logic clear_last;
      logic mark_last;
   } sts_type;

endpackage

### src/cba_chan_if.sv
interface cba_req_if;
   logic                       valid;
   logic                       ready;
   logic                       operation;
   logic [cba_pkg::ID_W-1:0]   file_id;
   logic [cba_pkg::REQ_W-1:0]  requested_blocks;

   modport source (output valid, operation, file_id, requested_blocks, input ready);
   modport sink (input valid, operation, file_id, requested_blocks, output ready);
endinterface

interface cba_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [cba_pkg::STATUS_W-1:0]  status;
   logic [cba_pkg::START_W-1:0]   start_block;
   logic [cba_pkg::COUNT_W-1:0]   block_count;

   modport source (output valid, status, start_block, block_count, input ready);
   modport sink (input valid, status, start_block, block_count, output ready);
endinterface

interface cba_csr_if;
   logic                       valid;
   logic                       ready;
   logic [cba_pkg::CFG_W-1:0]  disk_blocks_in_use;

   modport source (output valid, disk_blocks_in_use, input ready);
   modport sink (input valid, disk_blocks_in_use, output ready);
endinterface

### src/cba_dpath.sv
module cba_dpath (
   input  logic                           clock,
   input  logic                           reset,
   input  cba_pkg::cmd_type               cmd,
   output cba_pkg::sts_type               sts,
   input  logic                           csr_write,
   input  logic [cba_pkg::CFG_W-1:0]      csr_data,
   input  logic                           req_operation,
   input  logic [cba_pkg::ID_W-1:0]       req_file_id,
   input  logic [cba_pkg::REQ_W-1:0]      req_requested_blocks,
   output logic [cba_pkg::STATUS_W-1:0]   rsp_status,
   output logic [cba_pkg::START_W-1:0]    rsp_start_block,
   output logic [cba_pkg::COUNT_W-1:0]    rsp_block_count
);

   logic [cba_pkg::CFG_W-1:0]  limit_ff, limit_in;
   logic                       op_ff, op_in;
   logic [cba_pkg::ID_W-1:0]   id_ff, id_in;
   logic [cba_pkg::REQ_W-1:0]  want_ff, want_in;
   logic [cba_pkg::DIR_W-1:0]  dir_idx_ff, dir_idx_in;
   logic [cba_pkg::BLK_W-1:0]  map_idx_ff, map_idx_in;
   logic                       match_found_ff, match_found_in;
   logic [cba_pkg::DIR_W-1:0]  match_idx_ff, match_idx_in;
   logic                       slot_found_ff, slot_found_in;
   logic [cba_pkg::DIR_W-1:0]  slot_idx_ff, slot_idx_in;
   logic [cba_pkg::CNT_W-1:0]  run_ff, run_in;
   logic [cba_pkg::BLK_W-1:0]  run_start_ff, run_start_in;
   logic                       run_found_ff, run_found_in;
   logic [cba_pkg::CNT_W-1:0]  free_ff, free_in;
   logic [cba_pkg::BLK_W-1:0]  mark_idx_ff, mark_idx_in;
   logic [cba_pkg::REQ_W-1:0]  mark_left_ff, mark_left_in;

   logic                                 used_mem [cba_pkg::MAX_DISK_BLOCKS];
   logic                                 used_rd_ff;
   logic                                 entry_valid_ff [cba_pkg::DIRECTORY_ENTRIES];
   logic                                 entry_valid_in [cba_pkg::DIRECTORY_ENTRIES];
   logic [cba_pkg::ID_W-1:0]             entry_id_ff [cba_pkg::DIRECTORY_ENTRIES];
   logic [cba_pkg::BLK_W-1:0]            entry_start_ff [cba_pkg::DIRECTORY_ENTRIES];
   logic [cba_pkg::REQ_W-1:0]            entry_length_ff [cba_pkg::DIRECTORY_ENTRIES];

   logic [cba_pkg::STATUS_W-1:0]  status_ff, status_in;
   logic [cba_pkg::START_W-1:0]   start_ff, start_in;
   logic [cba_pkg::COUNT_W-1:0]   count_ff, count_in;

   logic                                 dir_hit;
   logic                                 dir_empty;
   logic                                 blk_used;
   logic                                 in_limit;
   logic [cba_pkg::CNT_W-1:0]            run_next;
   logic [cba_pkg::STATUS_W-1:0]         res_status;
   logic [cba_pkg::BLK_W-1:0]            sel_start;
   logic [cba_pkg::REQ_W-1:0]            sel_len;
   logic [cba_pkg::SUM_W-1:0]            sel_end;
   logic                                 commit;
   logic                                 is_create;

   assign is_create = (op_ff == cba_pkg::OP_CREATE);
   assign dir_hit   = entry_valid_ff[dir_idx_ff] && (entry_id_ff[dir_idx_ff] == id_ff);
   assign dir_empty = !entry_valid_ff[dir_idx_ff];
   assign blk_used  = used_rd_ff;
   assign in_limit  = cba_pkg::SUM_W'(map_idx_ff) < cba_pkg::SUM_W'(limit_ff);
   assign run_next  = run_ff + cba_pkg::CNT_W'(1);

   assign sts.dir_last = (dir_idx_ff == cba_pkg::DIR_W'(cba_pkg::DIRECTORY_ENTRIES - 1));
   assign sts.map_last = (map_idx_ff == cba_pkg::BLK_W'(cba_pkg::MAX_DISK_BLOCKS - 1));
   // A delete or a duplicate id needs no map scan; the hit of the last entry counts too.
   assign sts.skip_map = !is_create || match_found_ff || dir_hit;
   assign sts.res_ok   = (res_status == cba_pkg::ST_OK);
   assign sts.clear_last = (mark_idx_ff == cba_pkg::BLK_W'(cba_pkg::MAX_DISK_BLOCKS - 1));
   assign sts.mark_last  = (mark_left_ff == cba_pkg::REQ_W'(1));

   always_comb begin
      limit_in       = csr_write ? csr_data : limit_ff;
      op_in          = op_ff;
      id_in          = id_ff;
      want_in        = want_ff;
      dir_idx_in     = dir_idx_ff;
      map_idx_in     = map_idx_ff;
      match_found_in = match_found_ff;
      match_idx_in   = match_idx_ff;
      slot_found_in  = slot_found_ff;
      slot_idx_in    = slot_idx_ff;
      run_in         = run_ff;
      run_start_in   = run_start_ff;
      run_found_in   = run_found_ff;
      free_in        = free_ff;

      if (cmd.load) begin
         op_in          = req_operation;
         id_in          = req_file_id;
         want_in        = req_requested_blocks;
         dir_idx_in     = '0;
         map_idx_in     = '0;
         match_found_in = 1'b0;
         match_idx_in   = '0;
         slot_found_in  = 1'b0;
         slot_idx_in    = '0;
         run_in         = '0;
         run_start_in   = '0;
         run_found_in   = 1'b0;
         free_in        = '0;
      end

      if (cmd.dir_step) begin
         dir_idx_in = dir_idx_ff + cba_pkg::DIR_W'(1);
         if (dir_hit && !match_found_ff) begin
            match_found_in = 1'b1;
            match_idx_in   = dir_idx_ff;
         end
         if (dir_empty && !slot_found_ff) begin
            slot_found_in = 1'b1;
            slot_idx_in   = dir_idx_ff;
         end
      end

      // The free count runs over the whole managed range, while the run
      // search freezes at the first run that is long enough.
      if (cmd.map_step) begin
         map_idx_in = map_idx_ff + cba_pkg::BLK_W'(1);
         if (in_limit) begin
            if (blk_used) begin
               if (!run_found_ff) begin
                  run_in = '0;
               end
            end else begin
               free_in = free_ff + cba_pkg::CNT_W'(1);
               if (!run_found_ff) begin
                  if (run_ff == '0) begin
                     run_start_in = map_idx_ff;
                  end
                  run_in = run_next;
                  if ((want_ff != '0) &&
                      (cba_pkg::SUM_W'(run_next) == cba_pkg::SUM_W'(want_ff))) begin
                     run_found_in = 1'b1;
                  end
               end
            end
         end
      end
   end

   always_comb begin
      if (is_create) begin
         sel_start = run_start_ff;
         sel_len   = want_ff;
         if (match_found_ff) begin
            res_status = cba_pkg::ST_DUP;
         end else if (cba_pkg::SUM_W'(free_ff) < cba_pkg::SUM_W'(want_ff)) begin
            res_status = cba_pkg::ST_FEW;
         end else if (!run_found_ff) begin
            res_status = cba_pkg::ST_NORUN;
         end else if (!slot_found_ff) begin
            res_status = cba_pkg::ST_FULL;
         end else begin
            res_status = cba_pkg::ST_OK;
         end
      end else begin
         sel_start  = entry_start_ff[match_idx_ff];
         sel_len    = entry_length_ff[match_idx_ff];
         res_status = match_found_ff ? cba_pkg::ST_OK : cba_pkg::ST_NOTFOUND;
      end
   end

   assign sel_end = cba_pkg::SUM_W'(sel_start) + cba_pkg::SUM_W'(sel_len);
   assign commit  = cmd.finish && (res_status == cba_pkg::ST_OK);

   // One pointer walks the whole map after reset to clear it, and walks the
   // run of a committed transaction to mark or free it.
   always_comb begin
      mark_idx_in  = mark_idx_ff;
      mark_left_in = mark_left_ff;
      if (commit) begin
         mark_idx_in  = sel_start;
         mark_left_in = sel_len;
      end
      if (cmd.clear_step || cmd.mark_step) begin
         mark_idx_in = mark_idx_ff + cba_pkg::BLK_W'(1);
      end
      if (cmd.mark_step) begin
         mark_left_in = mark_left_ff - cba_pkg::REQ_W'(1);
      end
   end

   always_comb begin
      for (int e = 0; e < cba_pkg::DIRECTORY_ENTRIES; e++) begin
         entry_valid_in[e] = entry_valid_ff[e];
      end
      if (commit && is_create) begin
         entry_valid_in[slot_idx_ff] = 1'b1;
      end
      if (commit && !is_create) begin
         entry_valid_in[match_idx_ff] = 1'b0;
      end
   end

   always_comb begin
      status_in = status_ff;
      start_in  = start_ff;
      count_in  = count_ff;
      if (cmd.finish) begin
         status_in = res_status;
         start_in  = (res_status == cba_pkg::ST_OK) ? cba_pkg::START_W'(sel_start) : '0;
         count_in  = (res_status == cba_pkg::ST_OK) ? cba_pkg::COUNT_W'(sel_len) : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff    <= cba_pkg::CFG_RESET;
         mark_idx_ff <= '0;
         for (int e = 0; e < cba_pkg::DIRECTORY_ENTRIES; e++) begin
            entry_valid_ff[e] <= 1'b0;
         end
      end else begin
         limit_ff    <= limit_in;
         mark_idx_ff <= mark_idx_in;
         for (int e = 0; e < cba_pkg::DIRECTORY_ENTRIES; e++) begin
            entry_valid_ff[e] <= entry_valid_in[e];
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      id_ff          <= id_in;
      want_ff        <= want_in;
      dir_idx_ff     <= dir_idx_in;
      map_idx_ff     <= map_idx_in;
      match_found_ff <= match_found_in;
      match_idx_ff   <= match_idx_in;
      slot_found_ff  <= slot_found_in;
      slot_idx_ff    <= slot_idx_in;
      run_ff         <= run_in;
      run_start_ff   <= run_start_in;
      run_found_ff   <= run_found_in;
      free_ff        <= free_in;
      mark_left_ff   <= mark_left_in;
      status_ff      <= status_in;
      start_ff       <= start_in;
      count_ff       <= count_in;
   end

   // The read address is the next value of the scan index, so the
   // registered bit lines up with map_idx_ff during the map scan.
   always_ff @(posedge clock) begin
      if (cmd.clear_step || cmd.mark_step) begin
         used_mem[mark_idx_ff] <= cmd.mark_step && is_create;
      end
      used_rd_ff <= used_mem[map_idx_in];
   end

   always_ff @(posedge clock) begin
      if (commit && is_create) begin
         entry_id_ff[slot_idx_ff]     <= id_ff;
         entry_start_ff[slot_idx_ff]  <= run_start_ff;
         entry_length_ff[slot_idx_ff] <= want_ff;
      end
   end

   assign rsp_status      = status_ff;
   assign rsp_start_block = start_ff;
   assign rsp_block_count = count_ff;

   a_alloc_fits: assert property (@(posedge clock) disable iff (reset)
      (commit && is_create) |->
      (sel_end <= cba_pkg::SUM_W'(cba_pkg::MAX_DISK_BLOCKS)))
      else $error("allocated run extends past the disk");

   a_slot_empty: assert property (@(posedge clock) disable iff (reset)
      (commit && is_create) |-> !entry_valid_ff[slot_idx_ff])
      else $error("create overwrites a live directory entry");

   a_delete_live: assert property (@(posedge clock) disable iff (reset)
      (commit && !is_create) |-> entry_valid_ff[match_idx_ff])
      else $error("delete clears an empty directory entry");

   a_mark_count: assert property (@(posedge clock) disable iff (reset)
      cmd.mark_step |-> (mark_left_ff != '0))
      else $error("mark pass runs past the end of its run");

endmodule

### src/cba_ctrl.sv
module cba_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  cba_pkg::sts_type  sts,
   output cba_pkg::cmd_type  cmd
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_CLEAR = 3'd1;
   localparam logic [2:0] ST_DIR   = 3'd2;
   localparam logic [2:0] ST_MAP   = 3'd3;
   localparam logic [2:0] ST_FIN   = 3'd4;
   localparam logic [2:0] ST_MARK  = 3'd5;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   assign req_ready      = (state_ff == ST_IDLE);
   assign cmd.load       = req_valid && req_ready;
   assign cmd.dir_step   = (state_ff == ST_DIR);
   assign cmd.map_step   = (state_ff == ST_MAP);
   // The result is committed only once the output register can take it.
   assign cmd.finish     = (state_ff == ST_FIN) && (!rsp_valid_ff || rsp_ready);
   assign cmd.clear_step = (state_ff == ST_CLEAR);
   assign cmd.mark_step  = (state_ff == ST_MARK);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd.load) begin
               state_in = ST_DIR;
            end
         end
         ST_CLEAR: begin
            if (sts.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_DIR: begin
            if (sts.dir_last) begin
               state_in = sts.skip_map ? ST_FIN : ST_MAP;
            end
         end
         ST_MAP: begin
            if (sts.map_last) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (cmd.finish) begin
               state_in = sts.res_ok ? ST_MARK : ST_IDLE;
            end
         end
         ST_MARK: begin
            if (sts.mark_last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_finish_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> rsp_valid_ff)
      else $error("finished transaction did not reach the output register");

   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> rsp_valid_ff)
      else $error("response dropped before it was taken");

endmodule

### src/contiguous_block_allocator.sv
// First-fit contiguous block allocator. Each request transaction is a create
// (file id and block count) or a delete (file id); each gives exactly one
// response transaction with a status, the first block and the block count.
// After reset the block map is cleared one block per cycle, so no request is
// taken before the whole map is clear. A request first walks the directory,
// one entry per cycle, and a create that passes the duplicate check then walks
// the block map, one block per cycle over the full built size. The response is
// then registered, and a successful request marks or frees its run one block
// per cycle before the next request is taken. A response still waiting in the
// output register holds the next request after its last scan step, before it
// commits. The user is to write the managed disk size on the csr channel only
// between requests; the block itself does not enforce this. Written so, it
// takes effect for the next request.
module contiguous_block_allocator (
   input  logic             clock,
   input  logic             reset,
   cba_req_if.sink          req_chan,
   cba_rsp_if.source        rsp_chan,
   cba_csr_if.sink          csr_chan
);

   cba_pkg::cmd_type cmd;
   cba_pkg::sts_type sts;
   logic             csr_write;

   assign csr_chan.ready = 1'b1;
   assign csr_write      = csr_chan.valid && csr_chan.ready;

   cba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   cba_dpath u_dpath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .sts                  (sts),
      .csr_write            (csr_write),
      .csr_data             (csr_chan.disk_blocks_in_use),
      .req_operation        (req_chan.operation),
      .req_file_id          (req_chan.file_id),
      .req_requested_blocks (req_chan.requested_blocks),
      .rsp_status           (rsp_chan.status),
      .rsp_start_block      (rsp_chan.start_block),
      .rsp_block_count      (rsp_chan.block_count)
   );

endmodule

### tb/sv/tb_top.sv
module tb_top;

   localparam int STALL_LIMIT   = 20000;
   localparam int HOLDOFF_CYCLES = 1500;
   localparam int DRAIN_CYCLES  = 300;
   localparam int ID_POOL_SIZE  = 24;

   typedef struct packed {
      logic                        op;
      logic [cba_pkg::ID_W-1:0]    id;
      logic [cba_pkg::REQ_W-1:0]   want;
   } alloc_request_type;

   typedef struct packed {
      logic [cba_pkg::STATUS_W-1:0] status;
      logic [cba_pkg::START_W-1:0]  start_block;
      logic [cba_pkg::COUNT_W-1:0]  block_count;
   } alloc_result_type;

   logic clock;
   logic reset;

   cba_req_if req_ch();
   cba_rsp_if rsp_ch();
   cba_csr_if csr_ch();

   contiguous_block_allocator dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_ch),
      .rsp_chan (rsp_ch),
      .csr_chan (csr_ch)
   );

   // Shadow copy of the allocator state.
   bit                        blk_used  [cba_pkg::MAX_DISK_BLOCKS];
   bit                        dir_live  [cba_pkg::DIRECTORY_ENTRIES];
   logic [cba_pkg::ID_W-1:0]  dir_id    [cba_pkg::DIRECTORY_ENTRIES];
   int                        dir_start [cba_pkg::DIRECTORY_ENTRIES];
   int                        dir_len   [cba_pkg::DIRECTORY_ENTRIES];
   logic [cba_pkg::CFG_W-1:0] managed_blocks = cba_pkg::CFG_RESET;

   alloc_request_type         pending_requests [$];
   alloc_result_type          expected_results [$];
   logic [cba_pkg::ID_W-1:0]  id_pool [ID_POOL_SIZE];

   int  mismatches = 0;
   int  idle_cycles = 0;
   int  holds_requested = 0;
   int  holds_started = 0;
   int  hold_left = 0;
   bit  steady_flow = 1'b0;

   always #4 clock = ~clock;

   function automatic alloc_result_type predict_allocation(alloc_request_type rq);
      alloc_result_type res;
      int lim, hit, slot, free_total, run, run_start;
      bit found;
      res = '0;
      res.status = cba_pkg::ST_OK;
      lim = (managed_blocks > cba_pkg::MAX_DISK_BLOCKS) ? cba_pkg::MAX_DISK_BLOCKS
                                                        : int'(managed_blocks);
      hit = -1;
      for (int k = 0; k < cba_pkg::DIRECTORY_ENTRIES; k++)
         if (hit < 0 && dir_live[k] && dir_id[k] == rq.id) hit = k;

      if (rq.op == cba_pkg::OP_DELETE) begin
         if (hit < 0) begin
            res.status = cba_pkg::ST_NOTFOUND;
         end else begin
            // The whole recorded run is freed, even past a shrunk disk limit.
            for (int i = dir_start[hit];
                 i < dir_start[hit] + dir_len[hit] && i < cba_pkg::MAX_DISK_BLOCKS; i++)
               blk_used[i] = 1'b0;
            dir_live[hit] = 1'b0;
            res.start_block = cba_pkg::START_W'(dir_start[hit]);
            res.block_count = cba_pkg::COUNT_W'(dir_len[hit]);
         end
         return res;
      end

      if (hit >= 0) begin
         res.status = cba_pkg::ST_DUP;
         return res;
      end
      free_total = 0;
      for (int i = 0; i < lim; i++)
         if (!blk_used[i]) free_total++;
      if (free_total < int'(rq.want)) begin
         res.status = cba_pkg::ST_FEW;
         return res;
      end
      found = 1'b0;
      run = 0;
      run_start = 0;
      if (rq.want != 0) begin
         for (int i = 0; i < lim && !found; i++) begin
            if (blk_used[i]) begin
               run = 0;
            end else begin
               if (run == 0) run_start = i;
               run++;
               if (run == int'(rq.want)) found = 1'b1;
            end
         end
      end
      if (!found) begin
         res.status = cba_pkg::ST_NORUN;
         return res;
      end
      slot = -1;
      for (int k = 0; k < cba_pkg::DIRECTORY_ENTRIES; k++)
         if (slot < 0 && !dir_live[k]) slot = k;
      if (slot < 0) begin
         res.status = cba_pkg::ST_FULL;
         return res;
      end
      for (int i = run_start;
           i < run_start + int'(rq.want) && i < cba_pkg::MAX_DISK_BLOCKS; i++)
         blk_used[i] = 1'b1;
      dir_live[slot]  = 1'b1;
      dir_id[slot]    = rq.id;
      dir_start[slot] = run_start;
      dir_len[slot]   = int'(rq.want);
      res.start_block = cba_pkg::START_W'(run_start);
      res.block_count = rq.want;
      return res;
   endfunction

   task automatic check_field(input string what, input logic [cba_pkg::COUNT_W-1:0] exp_v,
                              input logic [cba_pkg::COUNT_W-1:0] act_v);
      if (exp_v !== act_v) begin
         mismatches++;
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, exp_v, act_v);
      end
   endtask

   // Request driver: predicts each accepted transaction, then offers the next one.
   always @(posedge clock) begin : req_driver
      alloc_request_type nxt;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            nxt = '{req_ch.operation, req_ch.file_id, req_ch.requested_blocks};
            expected_results.push_back(predict_allocation(nxt));
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (pending_requests.size() != 0 &&
                (steady_flow || $urandom_range(0, 99) >= 12)) begin
               nxt = pending_requests.pop_front();
               req_ch.valid            <= 1'b1;
               req_ch.operation        <= nxt.op;
               req_ch.file_id          <= nxt.id;
               req_ch.requested_blocks <= nxt.want;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor: checks each transaction against the oldest prediction.
   always @(posedge clock) begin : rsp_monitor
      alloc_result_type exp_res;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_results.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected response, expected none, %s %0d start %0d count %0d",
                        $time, "got status", rsp_ch.status, rsp_ch.start_block,
                        rsp_ch.block_count);
            end else begin
               exp_res = expected_results.pop_front();
               check_field("status", cba_pkg::COUNT_W'(exp_res.status),
                           cba_pkg::COUNT_W'(rsp_ch.status));
               check_field("start_block", cba_pkg::COUNT_W'(exp_res.start_block),
                           cba_pkg::COUNT_W'(rsp_ch.start_block));
               check_field("block_count", exp_res.block_count, rsp_ch.block_count);
            end
         end
         if (holds_started != holds_requested) begin
            holds_started++;
            hold_left = HOLDOFF_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= steady_flow || $urandom_range(0, 99) >= 12;
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
         $display("tb_top NOT OK");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic add_request(input logic op, input logic [cba_pkg::ID_W-1:0] id,
                              input logic [cba_pkg::REQ_W-1:0] want);
      pending_requests.push_back('{op, id, want});
   endtask

   task automatic add_random_requests(input int count);
      logic [cba_pkg::ID_W-1:0]  id;
      logic [cba_pkg::REQ_W-1:0] want;
      int r;
      for (int n = 0; n < count; n++) begin
         id = ($urandom_range(0, 99) < 8) ? cba_pkg::ID_W'($urandom)
                                          : id_pool[$urandom_range(0, ID_POOL_SIZE - 1)];
         r = $urandom_range(0, 99);
         if (r < 65)      want = cba_pkg::REQ_W'($urandom_range(1, 16));
         else if (r < 88) want = cba_pkg::REQ_W'($urandom_range(17, 64));
         else if (r < 97) want = cba_pkg::REQ_W'($urandom_range(65, 256));
         else             want = cba_pkg::REQ_W'($urandom_range(0, 511));
         add_request(($urandom_range(0, 99) < 55) ? cba_pkg::OP_CREATE : cba_pkg::OP_DELETE,
                     id, want);
      end
   endtask

   task automatic wait_idle();
      @(negedge clock);
      while (pending_requests.size() != 0 || req_ch.valid || expected_results.size() != 0)
         @(negedge clock);
   endtask

   task automatic set_disk_limit(input logic [cba_pkg::CFG_W-1:0] blocks);
      @(posedge clock);
      csr_ch.valid              <= 1'b1;
      csr_ch.disk_blocks_in_use <= blocks;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid   <= 1'b0;
      managed_blocks = blocks;
      @(negedge clock);
   endtask

   initial begin : stimulus
      int phase_limit [8];
      clock = 1'b0;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.operation = cba_pkg::OP_CREATE;
      req_ch.file_id = '0;
      req_ch.requested_blocks = '0;
      rsp_ch.ready = 1'b0;
      csr_ch.valid = 1'b0;
      csr_ch.disk_blocks_in_use = '0;
      phase_limit = '{256, 1, 64, 511, 200, 0, 17, 256};
      id_pool[0] = '0;
      id_pool[1] = '1;
      for (int k = 2; k < ID_POOL_SIZE; k++) id_pool[k] = cba_pkg::ID_W'($urandom);

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Full disk: missing file, zero-size create, duplicate, exhaustion and first fit.
      add_request(cba_pkg::OP_DELETE, 16'h0005, 9'd0);
      add_request(cba_pkg::OP_CREATE, 16'h0000, 9'd0);
      add_request(cba_pkg::OP_CREATE, 16'h0000, 9'd1);
      add_request(cba_pkg::OP_CREATE, 16'h0000, 9'd3);
      add_request(cba_pkg::OP_CREATE, 16'hFFFF, 9'd257);
      add_request(cba_pkg::OP_CREATE, 16'hFFFF, 9'd255);
      add_request(cba_pkg::OP_DELETE, 16'h0000, 9'd0);
      add_request(cba_pkg::OP_CREATE, 16'h0001, 9'd2);
      add_request(cba_pkg::OP_CREATE, 16'h0001, 9'd1);
      add_request(cba_pkg::OP_DELETE, 16'hFFFF, 9'd511);
      add_request(cba_pkg::OP_CREATE, 16'h0002, 9'd511);
      add_request(cba_pkg::OP_CREATE, 16'h0F0F, 9'd20);
      add_request(cba_pkg::OP_CREATE, 16'hF0F0, 9'd4);
      wait_idle();

      // Shrink the disk below files already placed past the new limit.
      set_disk_limit(9'd8);
      add_request(cba_pkg::OP_CREATE, 16'h0007, 9'd1);
      add_request(cba_pkg::OP_DELETE, 16'h0F0F, 9'd0);
      add_request(cba_pkg::OP_CREATE, 16'h0009, 9'd3);
      add_request(cba_pkg::OP_CREATE, 16'h000A, 9'd2);
      add_request(cba_pkg::OP_DELETE, 16'h0001, 9'd0);
      add_request(cba_pkg::OP_DELETE, 16'h0009, 9'd0);
      add_request(cba_pkg::OP_CREATE, 16'h000B, 9'd5);
      add_request(cba_pkg::OP_CREATE, 16'h000B, 9'd7);
      wait_idle();

      // A limit of zero manages nothing; an oversized limit acts as the built size.
      set_disk_limit(9'd0);
      add_request(cba_pkg::OP_CREATE, 16'h000C, 9'd0);
      add_request(cba_pkg::OP_CREATE, 16'h000C, 9'd1);
      wait_idle();
      set_disk_limit(9'd511);
      add_request(cba_pkg::OP_CREATE, 16'h000D, 9'd256);
      add_request(cba_pkg::OP_DELETE, 16'h000A, 9'd0);
      wait_idle();

      for (int p = 0; p < 8; p++) begin
         set_disk_limit(cba_pkg::CFG_W'(phase_limit[p]));
         steady_flow = (p == 2);
         add_random_requests(250);
         // Hold the response side off so the allocator backs up its request side.
         if (p == 4) holds_requested++;
         wait_idle();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && expected_results.size() == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

endmodule
